[src/cray_pkg.sv]
`timescale 1ns / 1ps

package cray_pkg;

  // Default frame dimension limit
  localparam int MAX_DIM_DEF = 4096;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_INPLANE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTICAL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd5;

  localparam logic [31:0] ROT_RESET    = 32'h4000_0000;
  localparam logic [23:0] FOCAL_RESET  = 24'd40960;
  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  // Datapath widths
  localparam int PIX_W = 12;   // pixel index
  localparam int VW    = 32;   // rotated component, signed
  localparam int PW    = 48;   // rotation product, signed
  localparam int MW    = 29;   // component magnitude
  localparam int SW    = 60;   // sum of squares
  localparam int LW    = 30;   // root, one bit per stage
  localparam int NW    = 46;   // dividend
  localparam int DW    = 31;   // divisor
  localparam int QW    = 17;   // quotient, one bit per stage
  localparam int OW    = 16;   // Q1.15 output

  localparam int NORM_BIT = 26;

  typedef struct packed {
    logic [31:0] rot_inplane;
    logic [31:0] rot_vertical;
    logic [31:0] rot_horizontal;
    logic [23:0] focal;
    logic [12:0] width;
    logic [12:0] height;
  } cam_cfg_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [MW-1:0] mag_x;
    logic [MW-1:0] mag_y;
    logic [MW-1:0] mag_z;
    logic [2:0]    neg;    // x in bit 0
    logic          zero;
  } norm_item_t;

  typedef struct packed {
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
    logic [QW-1:0] q_z;
    logic [2:0]    neg;
    logic          zero;
  } div_item_t;

endpackage

[src/cray_rotate.sv]
`timescale 1ns / 1ps

module cray_rotate #(
  parameter int MAX_DIM = cray_pkg::MAX_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [cray_pkg::PIX_W-1:0] col,
  input  logic [cray_pkg::PIX_W-1:0] row,
  input  cray_pkg::cam_cfg_t        cfg,
  output logic                      out_valid,
  output cray_pkg::vec_t            out_vec
);

  localparam int DIMW = $clog2(MAX_DIM + 1);

  function automatic logic signed [cray_pkg::VW-1:0] rnd14(
    input logic signed [cray_pkg::PW-1:0] p
  );
    logic signed [cray_pkg::PW-1:0] t;
    t = (p + 48'sd8192) >>> 14;
    return t[cray_pkg::VW-1:0];
  endfunction

  function automatic logic [DIMW-1:0] clamp_dim(input logic [12:0] d);
    if (d == 13'd0) return DIMW'(1);
    if (32'(d) > 32'(MAX_DIM)) return DIMW'(MAX_DIM);
    return DIMW'(d);
  endfunction

  logic [DIMW-1:0] w_c, h_c;
  logic signed [cray_pkg::VW-1:0] x_f, y_f;

  always_comb begin
    w_c = clamp_dim(cfg.width);
    h_c = clamp_dim(cfg.height);
    x_f = (signed'(32'(w_c)) - 32'sd1 - signed'(32'(col) << 1)) <<< 4;
    y_f = (signed'(32'(h_c)) - 32'sd1 - signed'(32'(row) << 1)) <<< 4;
  end

  // Plane point stage
  logic signed [cray_pkg::VW-1:0] f_r [3];
  logic                           f_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r[0] <= x_f;
      f_r[1] <= y_f;
      f_r[2] <= signed'(32'(cfg.focal));
    end
  end

  logic [31:0] rot_w [3];
  assign rot_w[0] = cfg.rot_inplane;
  assign rot_w[1] = cfg.rot_vertical;
  assign rot_w[2] = cfg.rot_horizontal;

  logic signed [cray_pkg::VW-1:0] a_r [3][3];
  logic                           a_v_r [3];

  for (genvar k = 0; k < 3; k++) begin : g_rot
    // in-plane (x,y), vertical (z,y), horizontal (z,x)
    localparam int IA = (k == 0) ? 0 : 2;
    localparam int IB = (k == 2) ? 0 : 1;
    localparam int IC = 3 - IA - IB;

    logic signed [cray_pkg::VW-1:0] src [3];
    logic                           src_v;
    logic signed [15:0]             c_s, s_s;
    logic signed [cray_pkg::PW-1:0] ac_r, bs_r, as_r, bc_r;
    logic signed [cray_pkg::VW-1:0] oth_r;
    logic                           m_v_r;

    if (k == 0) begin : g_src0
      assign src   = f_r;
      assign src_v = f_v_r;
    end else begin : g_srcn
      assign src   = a_r[k-1];
      assign src_v = a_v_r[k-1];
    end

    assign c_s = $signed(rot_w[k][31:16]);
    assign s_s = $signed(rot_w[k][15:0]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        m_v_r    <= 1'b0;
        a_v_r[k] <= 1'b0;
      end else if (en) begin
        m_v_r    <= src_v;
        a_v_r[k] <= m_v_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ac_r  <= src[IA] * c_s;
        bs_r  <= src[IB] * s_s;
        as_r  <= src[IA] * s_s;
        bc_r  <= src[IB] * c_s;
        oth_r <= src[IC];
        a_r[k][IA] <= rnd14(ac_r - bs_r);
        a_r[k][IB] <= rnd14(as_r + bc_r);
        a_r[k][IC] <= oth_r;
      end
    end
  end

  assign out_valid = a_v_r[2];
  assign out_vec.x = a_r[2][0];
  assign out_vec.y = a_r[2][1];
  assign out_vec.z = a_r[2][2];

endmodule

[src/cray_norm.sv]
`timescale 1ns / 1ps

module cray_norm (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  cray_pkg::vec_t            in_vec,
  output logic                      out_valid,
  output cray_pkg::norm_item_t      out_item,
  output logic [cray_pkg::SW-1:0]   out_sum
);

  localparam int MW = cray_pkg::MW;
  localparam int VW = cray_pkg::VW;
  localparam int SW = cray_pkg::SW;

  function automatic logic [MW-1:0] mag_of(input logic signed [cray_pkg::VW-1:0] v);
    logic signed [cray_pkg::VW-1:0] a;
    a = v[cray_pkg::VW-1] ? -v : v;
    return a[MW-1:0];
  endfunction

  // Magnitudes and largest
  logic [MW-1:0] ma_r [3];
  logic [MW-1:0] mx_r;
  logic [2:0]    na_r;
  logic          va_r;
  logic [MW-1:0] m0, m1, m2, mxy;

  always_comb begin
    m0  = mag_of(in_vec.x);
    m1  = mag_of(in_vec.y);
    m2  = mag_of(in_vec.z);
    mxy = (m0 > m1) ? m0 : m1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r[0] <= m0;
      ma_r[1] <= m1;
      ma_r[2] <= m2;
      mx_r    <= (mxy > m2) ? mxy : m2;
      na_r    <= {in_vec.z[VW-1], in_vec.y[VW-1], in_vec.x[VW-1]};
    end
  end

  // Normalizing shift
  logic [MW-1:0] mb_r [3];
  logic [2:0]    nb_r;
  logic          zb_r;
  logic          vb_r;
  logic [MW-1:0] m_t;
  logic [4:0]    sh;

  always_comb begin
    m_t = mx_r;
    sh  = 5'd0;
    for (int i = 4; i >= 0; i--) begin
      if (32'(m_t) < (32'd1 << (cray_pkg::NORM_BIT + 1 - (1 << i)))) begin
        m_t = m_t << (1 << i);
        sh  = sh + 5'(1 << i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mb_r[i] <= ma_r[i] << sh;
      end
      nb_r <= na_r;
      zb_r <= (mx_r == '0);
    end
  end

  // Squares and sum
  logic [2*MW-1:0]      sq_r [3];
  cray_pkg::norm_item_t ic_r;
  logic                 vc_r;
  logic [SW-1:0]        sum_r;
  cray_pkg::norm_item_t id_r;
  logic                 vd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= (2*MW)'(mb_r[i]) * (2*MW)'(mb_r[i]);
      end
      ic_r.mag_x <= mb_r[0];
      ic_r.mag_y <= mb_r[1];
      ic_r.mag_z <= mb_r[2];
      ic_r.neg   <= nb_r;
      ic_r.zero  <= zb_r;
      sum_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      id_r  <= ic_r;
    end
  end

  assign out_valid = vd_r;
  assign out_item  = id_r;
  assign out_sum   = sum_r;

endmodule

[src/cray_sqrt.sv]
`timescale 1ns / 1ps

module cray_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  cray_pkg::norm_item_t      in_item,
  input  logic [cray_pkg::SW-1:0]   in_sum,
  output logic                      out_valid,
  output cray_pkg::norm_item_t      out_item,
  output logic [cray_pkg::LW-1:0]   out_len
);

  localparam int SW = cray_pkg::SW;
  localparam int LW = cray_pkg::LW;

  logic [SW-1:0]          n_r   [LW];
  logic [SW-1:0]          res_r [LW];
  cray_pkg::norm_item_t   it_r  [LW];
  logic                   v_r   [LW];

  // One root bit per stage, highest first
  for (genvar i = 0; i < LW; i++) begin : g_stage
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (LW - 1 - i));

    logic [SW-1:0]        n_in, res_in, trial;
    cray_pkg::norm_item_t it_in;
    logic                 v_in;

    if (i == 0) begin : g_first
      assign n_in   = in_sum;
      assign res_in = '0;
      assign it_in  = in_item;
      assign v_in   = in_valid;
    end else begin : g_next
      assign n_in   = n_r[i-1];
      assign res_in = res_r[i-1];
      assign it_in  = it_r[i-1];
      assign v_in   = v_r[i-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_r[i] <= it_in;
        if (n_in >= trial) begin
          n_r[i]   <= n_in - trial;
          res_r[i] <= (res_in >> 1) + BIT;
        end else begin
          n_r[i]   <= n_in;
          res_r[i] <= res_in >> 1;
        end
      end
    end
  end

  assign out_valid = v_r[LW-1];
  assign out_item  = it_r[LW-1];
  assign out_len   = res_r[LW-1][LW-1:0];

endmodule

[src/cray_div.sv]
`timescale 1ns / 1ps

module cray_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  cray_pkg::norm_item_t      in_item,
  input  logic [cray_pkg::LW-1:0]   in_len,
  output logic                      out_valid,
  output cray_pkg::div_item_t       out_item
);

  localparam int NW = cray_pkg::NW;
  localparam int DW = cray_pkg::DW;
  localparam int QW = cray_pkg::QW;
  localparam int CW = NW + 2;

  // Dividend mag*65536 + len, divisor 2*len
  logic [NW-1:0] fn_r [3];
  logic [DW-1:0] fd_r;
  logic [2:0]    fneg_r;
  logic          fz_r;
  logic          fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn_r[0] <= (NW'(in_item.mag_x) << 16) + NW'(in_len);
      fn_r[1] <= (NW'(in_item.mag_y) << 16) + NW'(in_len);
      fn_r[2] <= (NW'(in_item.mag_z) << 16) + NW'(in_len);
      fd_r    <= {in_len, 1'b0};
      fneg_r  <= in_item.neg;
      fz_r    <= in_item.zero;
    end
  end

  logic [NW-1:0] n_r   [QW][3];
  logic [QW-1:0] q_r   [QW][3];
  logic [DW-1:0] d_r   [QW];
  logic [2:0]    neg_r [QW];
  logic          z_r   [QW];
  logic          v_r   [QW];

  // One quotient bit per stage, highest first
  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int SH = QW - 1 - j;

    logic [NW-1:0] n_in [3];
    logic [QW-1:0] q_in [3];
    logic [DW-1:0] d_in;
    logic [2:0]    neg_in;
    logic          z_in, v_in;
    logic [CW-1:0] dsh;

    if (j == 0) begin : g_first
      assign n_in   = fn_r;
      assign q_in   = '{default: '0};
      assign d_in   = fd_r;
      assign neg_in = fneg_r;
      assign z_in   = fz_r;
      assign v_in   = fv_r;
    end else begin : g_next
      assign n_in   = n_r[j-1];
      assign q_in   = q_r[j-1];
      assign d_in   = d_r[j-1];
      assign neg_in = neg_r[j-1];
      assign z_in   = z_r[j-1];
      assign v_in   = v_r[j-1];
    end

    assign dsh = CW'(d_in) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[j]   <= d_in;
        neg_r[j] <= neg_in;
        z_r[j]   <= z_in;
        for (int l = 0; l < 3; l++) begin
          if (CW'(n_in[l]) >= dsh) begin
            n_r[j][l] <= n_in[l] - dsh[NW-1:0];
            q_r[j][l] <= q_in[l] | (QW'(1) << SH);
          end else begin
            n_r[j][l] <= n_in[l];
            q_r[j][l] <= q_in[l];
          end
        end
      end
    end
  end

  assign out_valid     = v_r[QW-1];
  assign out_item.q_x  = q_r[QW-1][0];
  assign out_item.q_y  = q_r[QW-1][1];
  assign out_item.q_z  = q_r[QW-1][2];
  assign out_item.neg  = neg_r[QW-1];
  assign out_item.zero = z_r[QW-1];

endmodule

[src/camera_ray_direction_unit.sv]
`timescale 1ns / 1ps
// Depth: 60 register stages lie between the edge that accepts an item and out_tvalid.
// Throughput: one item per cycle unless the pipe halts on out_tready; each stage holds a multiply,
// an add, a compare or a shift, or one bit of the 30-bit root or of the three 17-bit quotients.
// Reset: synchronous, active low; clears every valid bit and loads the register defaults.
// No clearing pass: the block takes items in the first cycle after reset.

module camera_ray_direction_unit #(
  parameter int MAX_DIM = cray_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: pixel_column [11:0], pixel_row [23:12]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // tdata: dir_x [15:0], dir_y [31:16], dir_z [47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [cray_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cray_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers; writes to an unused index are dropped.
  // ---------------------------------------------------------------------------
  cray_pkg::cam_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot_inplane    <= cray_pkg::ROT_RESET;
      cfg_r.rot_vertical   <= cray_pkg::ROT_RESET;
      cfg_r.rot_horizontal <= cray_pkg::ROT_RESET;
      cfg_r.focal          <= cray_pkg::FOCAL_RESET;
      cfg_r.width          <= cray_pkg::WIDTH_RESET;
      cfg_r.height         <= cray_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cray_pkg::REG_INPLANE:    cfg_r.rot_inplane    <= cfg_data;
        cray_pkg::REG_VERTICAL:   cfg_r.rot_vertical   <= cfg_data;
        cray_pkg::REG_HORIZONTAL: cfg_r.rot_horizontal <= cfg_data;
        cray_pkg::REG_FOCAL:      cfg_r.focal          <= cfg_data[23:0];
        cray_pkg::REG_WIDTH:      cfg_r.width          <= cfg_data[12:0];
        cray_pkg::REG_HEIGHT:     cfg_r.height         <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance. Every stage moves together; the pipe only halts when
  // its last stage holds an item and the output register cannot take it, so
  // bubbles at the tail are squeezed out while a result waits downstream.
  // ---------------------------------------------------------------------------
  logic en;
  logic tail_valid;
  logic out_valid_r;
  logic [47:0] out_data_r;

  assign en        = !tail_valid || !out_valid_r || out_tready;
  assign in_tready = en;

  logic           rot_v;
  cray_pkg::vec_t rot_vec;

  cray_rotate #(.MAX_DIM(MAX_DIM)) u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .col       (in_tdata[11:0]),
    .row       (in_tdata[23:12]),
    .cfg       (cfg_r),
    .out_valid (rot_v),
    .out_vec   (rot_vec)
  );

  logic                         nrm_v;
  cray_pkg::norm_item_t         nrm_item;
  logic [cray_pkg::SW-1:0]      nrm_sum;

  cray_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rot_v),
    .in_vec    (rot_vec),
    .out_valid (nrm_v),
    .out_item  (nrm_item),
    .out_sum   (nrm_sum)
  );

  logic                         sq_v;
  cray_pkg::norm_item_t         sq_item;
  logic [cray_pkg::LW-1:0]      sq_len;

  cray_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (nrm_v),
    .in_item   (nrm_item),
    .in_sum    (nrm_sum),
    .out_valid (sq_v),
    .out_item  (sq_item),
    .out_len   (sq_len)
  );

  cray_pkg::div_item_t div_item;

  cray_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .in_item   (sq_item),
    .in_len    (sq_len),
    .out_valid (tail_valid),
    .out_item  (div_item)
  );

  // ---------------------------------------------------------------------------
  // Output register: saturate each quotient to Q1.15 and apply the sign.
  // A zero vector gives all components zero.
  // ---------------------------------------------------------------------------
  function automatic logic [cray_pkg::OW-1:0] sat_q(
    input logic [cray_pkg::QW-1:0] q,
    input logic neg,
    input logic zero
  );
    logic [cray_pkg::QW-1:0] m;
    if (zero) return '0;
    if (neg) begin
      m = (q > 17'd32768) ? 17'd32768 : q;
      m = -m;
    end else begin
      m = (q > 17'd32767) ? 17'd32767 : q;
    end
    return m[cray_pkg::OW-1:0];
  endfunction

  logic out_load;
  assign out_load = tail_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {sat_q(div_item.q_z, div_item.neg[2], div_item.zero),
                     sat_q(div_item.q_y, div_item.neg[1], div_item.zero),
                     sat_q(div_item.q_x, div_item.neg[0], div_item.zero)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_halt_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_valid && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while the pipe is halted");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !tail_valid) |=> !out_tvalid)
    else $error("result repeated after it was taken");

endmodule
